// ===== src/ckab_pkg.sv =====
// shared constants and types for the colour key alpha blend pixel unit
`timescale 1ns / 1ps

package ckab_pkg;

	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned PIXEL_W  = 3 * CHAN_W;
	localparam int unsigned OPA_W    = 7;
	localparam int unsigned SUM_W    = CHAN_W + OPA_W;
	localparam int unsigned RECIP_W  = 13;
	localparam int unsigned PROD_W   = SUM_W + RECIP_W;
	localparam int unsigned RECIP_SH = 19;

	localparam logic [OPA_W-1:0]   OPACITY_FULL = 7'd100;
	// 2^19 / 100 rounded up, exact for sums below 25600
	localparam logic [RECIP_W-1:0] RECIP_100    = 13'd5243;

	typedef enum logic [1:0] {
		REG_KEY_COLOR = 2'd0,
		REG_TOLERANCE = 2'd1,
		REG_OPACITY   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] key_color;
		logic [CHAN_W-1:0]  tolerance;
		logic [OPA_W-1:0]   opacity;
	} cfg_t;

endpackage

// ===== src/ckab_apb_regs.sv =====
// apb configuration registers: key colour, tolerance and clamped opacity
`timescale 1ns / 1ps

module ckab_apb_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output ckab_pkg::cfg_t      cfg
);
	import ckab_pkg::*;

	cfg_t             cfg_q;
	logic             wr_en;
	logic [OPA_W-1:0] opa_wr;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign opa_wr = (pwdata[OPA_W-1:0] > OPACITY_FULL) ? OPACITY_FULL : pwdata[OPA_W-1:0];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_color <= '0;
			cfg_q.tolerance <= '0;
			cfg_q.opacity   <= OPACITY_FULL;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_KEY_COLOR: cfg_q.key_color <= pwdata[PIXEL_W-1:0];
				REG_TOLERANCE: cfg_q.tolerance <= pwdata[CHAN_W-1:0];
				REG_OPACITY:   cfg_q.opacity   <= opa_wr;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_KEY_COLOR: prdata = {8'd0, cfg_q.key_color};
			REG_TOLERANCE: prdata = {24'd0, cfg_q.tolerance};
			REG_OPACITY:   prdata = {25'd0, cfg_q.opacity};
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== src/color_key_alpha_blend_pixel_unit.sv =====
// top level: colour key test and per-channel alpha blend of one pixel pair per word
//
// channel   dir   handshake          payload
// s_*       in    tvalid / tready    tdata = sprite_pixel, background_pixel
// m_*       out   tvalid / tready    tdata = blended_pixel, tuser = was_keyed
// apb       in    psel / penable     key_color @0x0, tolerance @0x4, opacity @0x8
//
// one word per cycle sustained while m_tready stays high, three register stages; an
// accepted word passes through all three before m_tvalid rises
// stages: input register, key test and products, reciprocal scale and select
// reset clears the stage valid bits and loads key 0, tolerance 0, opacity 100
// a low m_tready holds each stage that is full; empty stages still fill
`timescale 1ns / 1ps

module color_key_alpha_blend_pixel_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // sprite_pixel [23:0], background_pixel [47:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // blended_pixel [23:0]
	output logic [0:0]  m_tuser,  // was_keyed [0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ckab_pkg::*;

	cfg_t cfg;

	logic               v_s1, v_s2, v_s3;
	logic               adv1, adv2, adv3;
	logic [PIXEL_W-1:0] spr_s1, bg_s1;
	logic [PIXEL_W-1:0] bg_s2;
	logic [SUM_W-1:0]   sum_s2 [3];
	logic               keyed_s2;
	logic [PIXEL_W-1:0] pix_s3;
	logic               keyed_s3;

	logic               keyed_c;
	logic [SUM_W-1:0]   sum_c [3];
	logic [PROD_W-1:0]  prod_c [3];
	logic [PIXEL_W-1:0] pix_c;

	ckab_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv3     = !v_s3 || m_tready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;

	// key test and weighted sums
	always_comb begin
		logic [CHAN_W-1:0] s, b, c;
		logic [CHAN_W:0]   d;
		logic [OPA_W-1:0]  inv_opa;
		keyed_c = 1'b1;
		inv_opa = OPACITY_FULL - cfg.opacity;
		for (int k = 0; k < 3; k++) begin
			s = spr_s1[k*CHAN_W +: CHAN_W];
			b = bg_s1[k*CHAN_W +: CHAN_W];
			c = cfg.key_color[k*CHAN_W +: CHAN_W];
			d = (s >= c) ? ({1'b0, s} - {1'b0, c}) : ({1'b0, c} - {1'b0, s});
			if (d > {1'b0, cfg.tolerance}) begin
				keyed_c = 1'b0;
			end
			sum_c[k] = ({{OPA_W{1'b0}}, s} * {{CHAN_W{1'b0}}, cfg.opacity})
			         + ({{OPA_W{1'b0}}, b} * {{CHAN_W{1'b0}}, inv_opa});
		end
	end

	// divide by 100 through the reciprocal, then pick background when keyed
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod_c[k] = {{RECIP_W{1'b0}}, sum_s2[k]} * {{SUM_W{1'b0}}, RECIP_100};
			pix_c[k*CHAN_W +: CHAN_W] = keyed_s2 ? bg_s2[k*CHAN_W +: CHAN_W]
			                                     : prod_c[k][RECIP_SH +: CHAN_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			spr_s1 <= s_tdata[PIXEL_W-1:0];
			bg_s1  <= s_tdata[2*PIXEL_W-1:PIXEL_W];
		end
		if (adv2 && v_s1) begin
			bg_s2    <= bg_s1;
			sum_s2   <= sum_c;
			keyed_s2 <= keyed_c;
		end
		if (adv3 && v_s2) begin
			pix_s3   <= pix_c;
			keyed_s3 <= keyed_s2;
		end
	end

	assign m_tvalid   = v_s3;
	assign m_tdata    = pix_s3;
	assign m_tuser[0] = keyed_s3;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted word did not reach stage one");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv2) |=> (v_s1 && $stable(spr_s1) && $stable(bg_s1)))
		else $error("stalled stage one word lost or changed");

	a_key_flag_carried: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && adv3) |=> (m_tvalid && (m_tuser[0] == $past(keyed_s2))))
		else $error("key flag not carried to the output");

	a_quotient_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (!prod_c[0][PROD_W-1] && !prod_c[1][PROD_W-1] && !prod_c[2][PROD_W-1]))
		else $error("reciprocal product out of range");
`endif

endmodule
